// ===== sv/peak_average_envelope_history_defines.svh =====
`ifndef PEAK_AVERAGE_ENVELOPE_HISTORY_DEFINES_SVH
`define PEAK_AVERAGE_ENVELOPE_HISTORY_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define PAE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pae check failed");

// Next-cycle implication, ignored while reset is high.
`define PAE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pae check failed");

// Next-cycle implication that also watches the reset itself.
`define PAE_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pae check failed");

`endif

// ===== sv/pae_pkg.sv =====
`default_nettype none
package pae_pkg;

   localparam int HISTORY_DEPTH_DEF = 256;
   localparam int MAX_BLOCK_LEN_DEF = 4096;

   localparam int SAMPLE_W    = 16;
   localparam int OFFSET_W    = 10;
   localparam int LEN_W       = 13;
   localparam int VAL_W       = 18;
   localparam int SUM_W       = 30;
   localparam int MAG_W       = 17;
   localparam int PROD_W      = 32;
   localparam int SCALE_MUL   = 21300;
   localparam int SCALE_SHIFT = 12;

   localparam int REQ_W      = 32;
   localparam int RSP_W      = 40;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_BLOCK_LEN = 1'b0,
      REG_AVG_MODE  = 1'b1
   } pae_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_WRITE,
      ST_MARK
   } pae_state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_load;
      logic rd_en;
      logic wr_en;
      logic mark_en;
      logic clr_en;
   } pae_cmd_type;

   typedef struct packed {
      logic emit_now;
      logic avg_now;
      logic div_done;
      logic head_last;
      logic out_free;
   } pae_sts_type;

endpackage
`default_nettype wire

// ===== sv/pae_ctrl.sv =====
`default_nettype none
module pae_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  pae_pkg::pae_sts_type   sts,
   output pae_pkg::pae_cmd_type   cmd
);

   pae_pkg::pae_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pae_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pae_pkg::ST_CLEAR: begin
            if (sts.head_last) state_in = pae_pkg::ST_IDLE;
         end
         pae_pkg::ST_IDLE: begin
            if (req_tvalid && sts.emit_now) begin
               state_in = sts.avg_now ? pae_pkg::ST_DIVIDE : pae_pkg::ST_READ;
            end
         end
         pae_pkg::ST_DIVIDE: begin
            if (sts.div_done) state_in = pae_pkg::ST_READ;
         end
         pae_pkg::ST_READ: begin
            state_in = pae_pkg::ST_WRITE;
         end
         pae_pkg::ST_WRITE: begin
            if (sts.out_free) state_in = pae_pkg::ST_MARK;
         end
         pae_pkg::ST_MARK: begin
            state_in = pae_pkg::ST_IDLE;
         end
         default: begin
            state_in = pae_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pae_pkg::ST_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         pae_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.accept    = req_tvalid;
            cmd.div_start = req_tvalid && sts.emit_now && sts.avg_now;
         end
         pae_pkg::ST_DIVIDE: begin
            cmd.div_load = sts.div_done;
         end
         pae_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         pae_pkg::ST_WRITE: begin
            // hold until the output register is free
            cmd.wr_en = sts.out_free;
         end
         pae_pkg::ST_MARK: begin
            cmd.mark_en = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/pae_div.sv =====
`default_nettype none
module pae_div #(
   parameter int DIVD_W = pae_pkg::SUM_W,
   parameter int DIVS_W = pae_pkg::LEN_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVS_W-1:0] divisor,
   output logic      [DIVD_W-1:0] quotient,
   output logic                   done
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W:0]   trial;
   logic              take;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVD_W-1]};
      take  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // one quotient bit per cycle, dividend shifts out as quotient shifts in
         rem_in = take ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], take};
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== sv/pae_dp.sv =====
`default_nettype none
module pae_dp #(
   parameter int HISTORY_DEPTH = pae_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_BLOCK_LEN = pae_pkg::MAX_BLOCK_LEN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [pae_pkg::REQ_W-1:0]        req_tdata,
   input  pae_pkg::pae_cmd_type                  cmd,
   output pae_pkg::pae_sts_type                  sts,
   input  wire logic                             csr_we,
   input  wire logic [pae_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pae_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [pae_pkg::RSP_W-1:0]        rsp_tdata
);

   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int PTR1_W = PTR_W + 1;
   localparam int CNT_W  = (MAX_BLOCK_LEN > 1) ? $clog2(MAX_BLOCK_LEN) : 1;
   localparam int NEG_W  = pae_pkg::OFFSET_W + 1;
   localparam int CMP_W  = (PTR1_W > NEG_W) ? PTR1_W : NEG_W;
   localparam int VAL_W  = pae_pkg::VAL_W;
   localparam int SUM_W  = pae_pkg::SUM_W;
   localparam int LEN_W  = pae_pkg::LEN_W;
   localparam int PAD_W  = pae_pkg::RSP_W - 2 * VAL_W - 1;

   // configuration
   logic [LEN_W-1:0] block_len_ff;
   logic             avg_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= LEN_W'(1);
         avg_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (pae_pkg::pae_reg_type'(csr_addr))
            pae_pkg::REG_BLOCK_LEN: block_len_ff <= csr_wdata[LEN_W-1:0];
            pae_pkg::REG_AVG_MODE:  avg_mode_ff  <= csr_wdata[0];
            default:                block_len_ff <= block_len_ff;
         endcase
      end
   end

   // item fields
   logic [pae_pkg::SAMPLE_W-1:0] raw;
   logic                         beat;
   logic [pae_pkg::OFFSET_W-1:0] offset;

   assign raw    = req_tdata[pae_pkg::SAMPLE_W-1:0];
   assign beat   = req_tdata[pae_pkg::SAMPLE_W];
   assign offset = req_tdata[pae_pkg::SAMPLE_W+1 +: pae_pkg::OFFSET_W];

   // scale and fold
   logic [pae_pkg::MAG_W-1:0]  mag;
   logic [pae_pkg::PROD_W-1:0] prod;
   logic [VAL_W-1:0]           val;
   logic [LEN_W-1:0]           eff_len;
   logic [CNT_W:0]             count_inc;
   logic [VAL_W-1:0]           peak_new;
   logic [SUM_W-1:0]           sum_new;
   logic                       emit_now;

   always_comb begin
      mag = raw[pae_pkg::SAMPLE_W-1] ? pae_pkg::MAG_W'(~{raw[pae_pkg::SAMPLE_W-1], raw} + 1'b1)
                                     : {1'b0, raw};
      prod = pae_pkg::PROD_W'(mag) * pae_pkg::PROD_W'(pae_pkg::SCALE_MUL);
      val  = prod[pae_pkg::SCALE_SHIFT +: VAL_W];
      priority if (block_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (block_len_ff > LEN_W'(MAX_BLOCK_LEN)) begin
         eff_len = LEN_W'(MAX_BLOCK_LEN);
      end else begin
         eff_len = block_len_ff;
      end
   end

   logic [CNT_W-1:0] count_ff;
   logic [VAL_W-1:0] peak_ff;
   logic [SUM_W-1:0] sum_ff;

   always_comb begin
      count_inc = {1'b0, count_ff} + 1'b1;
      emit_now  = LEN_W'(count_inc) >= eff_len;
      peak_new  = (val > peak_ff) ? val : peak_ff;
      sum_new   = sum_ff + SUM_W'(val);
   end

   // beat request check
   logic [NEG_W-1:0] off_neg;
   logic             beat_ok;

   always_comb begin
      off_neg = NEG_W'(0) - {offset[pae_pkg::OFFSET_W-1], offset};
      beat_ok = beat && (offset[pae_pkg::OFFSET_W-1] || offset == '0)
                && (CMP_W'(off_neg) < CMP_W'(HISTORY_DEPTH));
   end

   logic             pend_ff;
   logic [PTR_W-1:0] pneg_ff;
   logic [VAL_W-1:0] env_ff;

   // divider for the block average
   logic [SUM_W-1:0] quotient;
   logic             div_done;

   pae_div #(
      .DIVD_W (SUM_W),
      .DIVS_W (LEN_W)
   ) u_pae_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_new),
      .divisor  (eff_len),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= '0;
         sum_ff   <= '0;
         pend_ff  <= 1'b0;
         pneg_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            count_ff <= emit_now ? '0 : count_inc[CNT_W-1:0];
            peak_ff  <= emit_now ? '0 : peak_new;
            sum_ff   <= emit_now ? '0 : sum_new;
            if (beat_ok) begin
               pend_ff <= 1'b1;
               pneg_ff <= PTR_W'(CMP_W'(off_neg));
            end
         end else if (cmd.mark_en) begin
            pend_ff <= 1'b0;
            pneg_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && emit_now) begin
         env_ff <= peak_new;
      end else if (cmd.div_load) begin
         env_ff <= quotient[VAL_W-1:0];
      end
   end

   // history ring: head is the oldest entry, the slot just written becomes the tail
   logic [PTR_W-1:0] head_ff, head_in;
   logic             head_last;
   logic [PTR_W-1:0] mark_pos;

   always_comb begin
      head_last = head_ff == PTR_W'(HISTORY_DEPTH - 1);
      head_in   = head_ff;
      if (cmd.clr_en || cmd.mark_en) begin
         head_in = head_last ? '0 : head_ff + 1'b1;
      end
      if (head_ff >= pneg_ff) begin
         mark_pos = head_ff - pneg_ff;
      end else begin
         mark_pos = PTR_W'({1'b0, head_ff} + PTR1_W'(HISTORY_DEPTH) - {1'b0, pneg_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   logic [VAL_W-1:0] val_mem [HISTORY_DEPTH];
   logic             beat_mem [HISTORY_DEPTH];
   logic [VAL_W-1:0] oldv_ff;
   logic             oldb_ff;
   logic             beat_we;
   logic [PTR_W-1:0] beat_addr;

   always_comb begin
      beat_we   = cmd.clr_en || cmd.wr_en || (cmd.mark_en && pend_ff);
      beat_addr = cmd.mark_en ? mark_pos : head_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en || cmd.wr_en) begin
         val_mem[head_ff] <= cmd.clr_en ? '0 : env_ff;
      end
      if (beat_we) begin
         beat_mem[beat_addr] <= cmd.mark_en;
      end
      if (cmd.rd_en) begin
         oldv_ff <= val_mem[head_ff];
         oldb_ff <= beat_mem[head_ff];
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [VAL_W-1:0] rsp_env_ff;
   logic [VAL_W-1:0] rsp_oldv_ff;
   logic             rsp_oldb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wr_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         rsp_env_ff  <= env_ff;
         rsp_oldv_ff <= oldv_ff;
         rsp_oldb_ff <= oldb_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_oldb_ff, rsp_oldv_ff, rsp_env_ff};

   always_comb begin
      sts.emit_now  = emit_now;
      sts.avg_now   = avg_mode_ff;
      sts.div_done  = div_done;
      sts.head_last = head_last;
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule
`default_nettype wire

// ===== sv/peak_average_envelope_history.sv =====
// A sample that does not close a block is taken while the controller stays idle.
// A closing sample passes through the read, write and mark states in peak mode; in
// average mode a divide state comes first, where a one-bit-a-cycle divider forms the
// block average. The result is registered in the write state once the previous result is taken.
// Synchronous reset, active high, then a clearing pass over every history entry
// zeroes the history RAM; req_tready stays low until it ends.
`default_nettype none
module peak_average_envelope_history #(
   parameter int HISTORY_DEPTH = pae_pkg::HISTORY_DEPTH_DEF,
   parameter int MAX_BLOCK_LEN = pae_pkg::MAX_BLOCK_LEN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // sample[15:0], beat[16], beat_offset[26:17], zero fill[31:27]
   input  wire logic [pae_pkg::REQ_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // envelope[17:0], oldest_value[35:18], oldest_beat[36], zero fill[39:37]
   output logic      [pae_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [pae_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [pae_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   pae_pkg::pae_cmd_type cmd;
   pae_pkg::pae_sts_type sts;

   pae_ctrl u_pae_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pae_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
   ) u_pae_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== sv/pae_checker.sv =====
`default_nettype none
`include "peak_average_envelope_history_defines.svh"
module pae_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [pae_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int VAL_W = pae_pkg::VAL_W;

   // a stalled item holds
   `PAE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // no item straight out of reset, and no intake while the history is cleared
   `PAE_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_tvalid && !req_tready)

   // fill bits above the fields stay zero
   `PAE_ASSERT_NOW(a_rsp_fill, rsp_tvalid, rsp_tdata[pae_pkg::RSP_W-1:2*VAL_W+1] == '0)

endmodule

bind peak_average_envelope_history pae_checker u_pae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
